// ===== sv/mdgp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mono downmix gain and pan mixer package
// Shared types, register indexes and constants of the mixer datapath.
// ----------------------------------------------------------------------------
package mdgp_pkg;

    // Q1.15 unity, also the ceiling of every coefficient
    localparam logic [15:0] Q_ONE = 16'd32768;

    // register reset values
    localparam logic       RST_SAMPLE_WIDTH = 1'b1;
    localparam logic       RST_CHANNEL_MODE = 1'b1;
    localparam logic [15:0] RST_GAIN        = 16'd32768;
    localparam logic [15:0] RST_LEFT_PAN    = 16'd23170;
    localparam logic [15:0] RST_RIGHT_PAN   = 16'd23170;

    // sample format and channel mode codes
    localparam logic SW_8BIT   = 1'b0;
    localparam logic CM_STEREO = 1'b1;

    typedef enum logic [2:0] {
        REG_SAMPLE_WIDTH = 3'd0,
        REG_CHANNEL_MODE = 3'd1,
        REG_GAIN         = 3'd2,
        REG_LEFT_PAN     = 3'd3,
        REG_RIGHT_PAN    = 3'd4
    } t_reg_idx;

    // configuration as seen by the datapath stages; coefficients already clamped
    typedef struct packed {
        logic        sample_width;
        logic        channel_mode;
        logic [15:0] gain;
        logic [15:0] left_pan;
        logic [15:0] right_pan;
    } t_cfg;

endpackage

// ===== sv/mdgp_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Normalise and downmix stage
// Brings raw samples to Q1.15 and averages a stereo frame to mono; in mono mode it passes the first sample.
// ----------------------------------------------------------------------------
module mdgp_norm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mdgp_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [15:0]         i_first,
    input  logic [15:0]         i_second,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_mono
);

    logic               r_vld;
    logic signed [15:0] r_mono;
    logic signed [15:0] n_mono;
    logic signed [15:0] a_q15;
    logic signed [15:0] b_q15;
    logic signed [16:0] sum;

    always_comb begin
        if (i_cfg.sample_width == mdgp_pkg::SW_8BIT) begin
            // (s - 128) << 8: flip the offset bit, move into the top byte
            a_q15 = {~i_first[7], i_first[6:0], 8'd0};
            b_q15 = {~i_second[7], i_second[6:0], 8'd0};
        end else begin
            a_q15 = i_first;
            b_q15 = i_second;
        end
        sum = 17'(a_q15) + 17'(b_q15);
        if (i_cfg.channel_mode == mdgp_pkg::CM_STEREO) begin
            n_mono = sum[16:1];
        end else begin
            n_mono = a_q15;
        end
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_mono <= n_mono;
        end
    end

    assign o_valid = r_vld;
    assign o_mono  = r_mono;

endmodule

// ===== sv/mdgp_gain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gain stage
// Multiplies the mono value by the Q1.15 gain with a floor shift of 15.
// ----------------------------------------------------------------------------
module mdgp_gain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mdgp_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_mono,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_scaled
);

    logic               r_vld;
    logic signed [15:0] r_scaled;
    logic signed [16:0] coef;
    logic signed [32:0] prod;

    assign coef = signed'({1'b0, i_cfg.gain});
    assign prod = coef * i_mono;
    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            // coefficient <= unity, so the floored product fits 16 bits
            r_scaled <= prod[30:15];
        end
    end

    assign o_valid  = r_vld;
    assign o_scaled = r_scaled;

endmodule

// ===== sv/mdgp_pan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pan stage
// Splits the scaled mono value into left and right by the pan coefficients.
// ----------------------------------------------------------------------------
module mdgp_pan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mdgp_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_scaled,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_left,
    output logic signed [15:0]  o_right
);

    logic               r_vld;
    logic signed [15:0] r_left;
    logic signed [15:0] r_right;
    logic signed [16:0] coef_l;
    logic signed [16:0] coef_r;
    logic signed [32:0] prod_l;
    logic signed [32:0] prod_r;

    assign coef_l  = signed'({1'b0, i_cfg.left_pan});
    assign coef_r  = signed'({1'b0, i_cfg.right_pan});
    assign prod_l  = coef_l * i_scaled;
    assign prod_r  = coef_r * i_scaled;
    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_left  <= prod_l[30:15];
            r_right <= prod_r[30:15];
        end
    end

    assign o_valid = r_vld;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

// ===== sv/mdgp_fin.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output scaling stage
// Scales each channel by 32767/32768 toward zero; holds the output request.
// ----------------------------------------------------------------------------
module mdgp_fin (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_left,
    input  logic signed [15:0]  i_right,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [15:0]  o_left,
    output logic signed [15:0]  o_right
);

    logic               r_vld;
    logic signed [15:0] r_left;
    logic signed [15:0] r_right;

    // v * 32767 / 32768, truncated toward zero; the input already lies in
    // [-1, 1) so no saturation is needed
    function automatic logic signed [15:0] scale_out(input logic signed [15:0] v);
        logic signed [31:0] p;
        logic signed [31:0] q;
        p = (32'(v) <<< 15) - 32'(v);
        q = p + (p[31] ? 32'sd32767 : 32'sd0);
        return q[30:15];
    endfunction

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_left  <= scale_out(i_left);
            r_right <= scale_out(i_right);
        end
    end

    assign o_valid = r_vld;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

// ===== sv/mono_downmix_gain_pan_mixer.sv =====
`timescale 1ns / 1ps
// An accepted input request passes the normalise, gain, pan and output registers to the master side.
// Throughput: one frame per cycle while the master side does not stall; the four register stages each hold one frame.
// A stall on the master side backs up stage by stage, dropping and repeating nothing.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults:
// 16-bit samples, stereo downmix, unity gain, both pan coefficients at 23170.
// ----------------------------------------------------------------------------
// Mono downmix gain and pan mixer
// Four-stage pipeline: normalise/downmix, gain, pan, output scaling.
// ----------------------------------------------------------------------------
module mono_downmix_gain_pan_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input frame stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] first_sample, [31:16] second_sample
    // output frame stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [15:0] left_out, [31:16] right_out
);

    // ------------------------------------------------------------------
    // Configuration registers; coefficients are clamped to unity on write
    // so the stages never see a value above Q1.15 one.
    // ------------------------------------------------------------------
    mdgp_pkg::t_cfg r_cfg;
    logic [15:0]    cfg_coef;
    logic [2:0]     r_occ;
    logic [2:0]     n_occ;

    // hold a write off until the pipeline is empty and no input request is
    // offered, so every frame sees one setting from entry to exit
    assign o_cfg_ready = (r_occ == 3'd0) && !i_s_tvalid;
    assign cfg_coef    = (i_cfg_data > mdgp_pkg::Q_ONE) ? mdgp_pkg::Q_ONE : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_width <= mdgp_pkg::RST_SAMPLE_WIDTH;
            r_cfg.channel_mode <= mdgp_pkg::RST_CHANNEL_MODE;
            r_cfg.gain         <= mdgp_pkg::RST_GAIN;
            r_cfg.left_pan     <= mdgp_pkg::RST_LEFT_PAN;
            r_cfg.right_pan    <= mdgp_pkg::RST_RIGHT_PAN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (mdgp_pkg::t_reg_idx'(i_cfg_index))
                mdgp_pkg::REG_SAMPLE_WIDTH: r_cfg.sample_width <= i_cfg_data[0];
                mdgp_pkg::REG_CHANNEL_MODE: r_cfg.channel_mode <= i_cfg_data[0];
                mdgp_pkg::REG_GAIN:         r_cfg.gain         <= cfg_coef;
                mdgp_pkg::REG_LEFT_PAN:     r_cfg.left_pan     <= cfg_coef;
                mdgp_pkg::REG_RIGHT_PAN:    r_cfg.right_pan    <= cfg_coef;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath. Each stage advances when its output slot is empty or the
    // stage after it takes the request, so bubbles collapse under stall.
    // ------------------------------------------------------------------
    logic               s1_valid, s1_ready;
    logic signed [15:0] s1_mono;
    logic               s2_valid, s2_ready;
    logic signed [15:0] s2_scaled;
    logic               s3_valid, s3_ready;
    logic signed [15:0] s3_left, s3_right;
    logic signed [15:0] s4_left, s4_right;

    // stage 1: Q1.15 normalisation and stereo average
    mdgp_norm u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_first  (i_s_tdata[15:0]),
        .i_second (i_s_tdata[31:16]),
        .o_valid  (s1_valid),
        .i_ready  (s1_ready),
        .o_mono   (s1_mono)
    );

    // stage 2: gain multiply
    mdgp_gain u_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s1_valid),
        .o_ready  (s1_ready),
        .i_mono   (s1_mono),
        .o_valid  (s2_valid),
        .i_ready  (s2_ready),
        .o_scaled (s2_scaled)
    );

    // stage 3: left and right pan multiplies
    mdgp_pan u_pan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s2_valid),
        .o_ready  (s2_ready),
        .i_scaled (s2_scaled),
        .o_valid  (s3_valid),
        .i_ready  (s3_ready),
        .o_left   (s3_left),
        .o_right  (s3_right)
    );

    // stage 4: output scaling, also the output register
    mdgp_fin u_fin (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s3_valid),
        .o_ready  (s3_ready),
        .i_left   (s3_left),
        .i_right  (s3_right),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_left   (s4_left),
        .o_right  (s4_right)
    );

    assign o_m_tdata = {s4_right, s4_left};

    // ------------------------------------------------------------------
    // Occupancy count of requests in flight; gates configuration writes
    // and feeds the checks below.
    // ------------------------------------------------------------------
    always_comb begin
        n_occ = r_occ;
        if (i_s_tvalid && o_s_tready) begin
            n_occ = n_occ + 3'd1;
        end
        if (o_m_tvalid && i_m_tready) begin
            n_occ = n_occ - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 3'd0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // pipeline never holds more requests than it has stages
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= 3'd4)
        else $error("mixer holds more than four requests");

    // input side only stalls when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready && r_occ == 3'd4))
        else $error("input stalled with room in the pipeline");

    // an empty pipeline shows no result
    a_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == 3'd0) |-> !o_m_tvalid)
        else $error("result shown with nothing in flight");

    // output scaling never yields full-scale negative
    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:0] != 16'h8000 && o_m_tdata[31:16] != 16'h8000))
        else $error("full-scale negative reached the output");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule
